/* hw/rtl/lcdseq_pkg.sv */
// ---------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, command codes and write tables for the LCD command sequencer.
// ---------------------------------------------------------------------------
package lcdseq_pkg;

    // input mode codes
    localparam logic [2:0] MODE_INIT       = 3'd0;
    localparam logic [2:0] MODE_SET_POS    = 3'd1;
    localparam logic [2:0] MODE_PUT_CHAR   = 3'd2;
    localparam logic [2:0] MODE_CLEAR      = 3'd3;
    localparam logic [2:0] MODE_CLEAR_LINE = 3'd4;

    // controller instruction bytes
    localparam logic [7:0] INSTR_FUNC_SET  = 8'h38;
    localparam logic [7:0] INSTR_DISP_ON   = 8'h0C;
    localparam logic [7:0] INSTR_CLEAR     = 8'h01;
    localparam logic [7:0] INSTR_ENTRY     = 8'h06;
    localparam logic [7:0] INSTR_SET_DDRAM = 8'h80;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;

    // display geometry
    localparam logic [7:0] ROW_MAX    = 8'd3;
    localparam logic [7:0] COL_MAX    = 8'd15;
    localparam logic [6:0] LINE0_BASE = 7'd0;
    localparam logic [6:0] LINE1_BASE = 7'd64;
    localparam logic [6:0] LINE2_BASE = 7'd16;
    localparam logic [6:0] LINE3_BASE = 7'd80;
    localparam logic [6:0] LINE0_END  = 7'd16;
    localparam logic [6:0] LINE1_END  = 7'd80;
    localparam logic [6:0] LINE2_END  = 7'd32;
    localparam logic [6:0] LINE3_END  = 7'd96;

    localparam logic [2:0] INIT_LAST_STEP = 3'd6;
    localparam logic [3:0] LINE_LAST_CHAR = 4'd15;

    typedef enum logic [2:0] {
        K_INIT,
        K_GOTO,
        K_CHAR,
        K_CLEAR,
        K_LINE
    } cmd_kind_t;

    // one classified command, as held in the queue
    typedef struct packed {
        cmd_kind_t  kind;
        logic       goto_en;    // clear line: positioning write wanted
        logic [6:0] addr;
        logic [7:0] char_code;
    } cmd_t;

    // one bus write
    typedef struct packed {
        logic        rs;
        logic [7:0]  data;
        logic        poll;
        logic [14:0] settle;
    } wr_t;

    function automatic wr_t init_write(input logic [2:0] idx);
        wr_t w;
        w = '{rs: 1'b0, data: INSTR_FUNC_SET, poll: 1'b0, settle: 15'd0};
        case (idx)
            3'd0: w.settle = 15'd17000;
            3'd1: w.settle = 15'd5000;
            3'd2: w.settle = 15'd120;
            3'd3: w.settle = 15'd120;
            3'd4: begin
                w.data   = INSTR_DISP_ON;
                w.poll   = 1'b1;
                w.settle = 15'd120;
            end
            3'd5: begin
                w.data = INSTR_CLEAR;
                w.poll = 1'b1;
            end
            default: begin
                w.data = INSTR_ENTRY;
                w.poll = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] b;
        case (row)
            2'd0:    b = LINE0_BASE;
            2'd1:    b = LINE1_BASE;
            2'd2:    b = LINE2_BASE;
            default: b = LINE3_BASE;
        endcase
        return b;
    endfunction

    function automatic logic is_line_end(input logic [6:0] a);
        return (a == LINE0_END) || (a == LINE1_END) || (a == LINE2_END) ||
               (a == LINE3_END);
    endfunction

    // start of the line that follows a line end
    function automatic logic [6:0] wrap_target(input logic [6:0] a);
        logic [6:0] t;
        case (a)
            LINE0_END: t = LINE1_BASE;
            LINE1_END: t = LINE2_BASE;
            LINE2_END: t = LINE3_BASE;
            default:   t = LINE0_BASE;
        endcase
        return t;
    endfunction

endpackage

/* hw/rtl/lcdseq_front.sv */
// ---------------------------------------------------------------------------
// lcdseq_front
// Accepts commands, checks positions and classifies them for the queue.
// ---------------------------------------------------------------------------
module lcdseq_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic [7:0]         s_row,
    input  logic [7:0]         s_column,
    input  logic [7:0]         s_char_code,
    output logic               push_valid,
    input  logic               push_ready,
    output lcdseq_pkg::cmd_t   push_data
);
    import lcdseq_pkg::*;

    logic row_ok;
    logic col_ok;
    logic keep;

    assign row_ok  = (s_row <= ROW_MAX);
    assign col_ok  = (s_column <= COL_MAX);
    assign s_ready = push_ready;

    always_comb begin
        keep                = 1'b1;
        push_data.kind      = K_INIT;
        push_data.goto_en   = row_ok;
        push_data.addr      = 7'(row_base(s_row[1:0]) + 7'(s_column[3:0]));
        push_data.char_code = s_char_code;
        unique case (s_mode)
            MODE_INIT:     push_data.kind = K_INIT;
            MODE_SET_POS: begin
                push_data.kind = K_GOTO;
                keep           = row_ok && col_ok;
            end
            MODE_PUT_CHAR: push_data.kind = K_CHAR;
            MODE_CLEAR:    push_data.kind = K_CLEAR;
            MODE_CLEAR_LINE: begin
                push_data.kind      = K_LINE;
                push_data.addr      = row_base(s_row[1:0]);
                push_data.char_code = CHAR_SPACE;
            end
            default:       keep = 1'b0;   // unknown modes are dropped
        endcase
    end

    assign push_valid = s_valid && keep;

endmodule

/* hw/rtl/lcdseq_queue.sv */
// ---------------------------------------------------------------------------
// lcdseq_queue
// Small command FIFO between front and back.
// ---------------------------------------------------------------------------
module lcdseq_queue #(
    parameter int DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  lcdseq_pkg::cmd_t   push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output lcdseq_pkg::cmd_t   pop_data
);
    import lcdseq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/lcdseq_back.sv */
// ---------------------------------------------------------------------------
// lcdseq_back
// Write sequencer: expands queued commands into bus writes, owns the cursor.
// ---------------------------------------------------------------------------
module lcdseq_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  lcdseq_pkg::cmd_t   pop_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_reg_select,
    output logic [7:0]         m_bus_data,
    output logic               m_poll_busy,
    output logic [14:0]        m_settle_us,
    output logic               m_last
);
    import lcdseq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_GOTO  = 6'b000100,
        S_CLEAR = 6'b001000,
        S_CHAR  = 6'b010000,
        S_WRAP  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [6:0] cursor_reg, cursor_next;
    logic [6:0] addr_reg, addr_next;
    logic [7:0] char_reg, char_next;
    logic       line_reg, line_next;
    logic       m_valid_reg, m_valid_next;
    wr_t        wr_out_reg;
    logic       m_last_reg;

    wr_t        wr;
    logic       wr_last;
    logic       out_ld;
    logic       fire;
    logic       done;
    logic       last_char;
    logic [6:0] cursor_inc;
    logic       wrap;

    assign out_ld     = !m_valid_reg || m_ready;
    assign fire       = (state_reg != S_IDLE) && out_ld;
    assign last_char  = !line_reg || (step_reg == LINE_LAST_CHAR);
    assign cursor_inc = cursor_reg + 7'd1;
    assign wrap       = is_line_end(cursor_inc);
    assign done       = (state_reg == S_IDLE) || (fire && wr_last);
    assign pop_ready  = done;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        cursor_next = cursor_reg;
        addr_next   = addr_reg;
        char_next   = char_reg;
        line_next   = line_reg;
        wr          = '{rs: 1'b0, data: INSTR_CLEAR, poll: 1'b1, settle: 15'd0};
        wr_last     = 1'b0;

        unique case (state_reg)
            S_IDLE: ;
            S_INIT: begin
                wr      = init_write(step_reg[2:0]);
                wr_last = (step_reg[2:0] == INIT_LAST_STEP);
                if (fire) begin
                    step_next = step_reg + 4'd1;
                    if (wr_last) begin
                        cursor_next = '0;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_GOTO: begin
                wr.data = INSTR_SET_DDRAM | {1'b0, addr_reg};
                wr_last = !line_reg;
                if (fire) begin
                    cursor_next = addr_reg;
                    state_next  = line_reg ? S_CHAR : S_IDLE;
                end
            end
            S_CLEAR: begin
                wr_last = 1'b1;
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            S_CHAR: begin
                wr.rs   = 1'b1;
                wr.data = char_reg;
                wr_last = !wrap && last_char;
                if (fire) begin
                    cursor_next = cursor_inc;
                    if (wrap) begin
                        state_next = S_WRAP;
                    end else if (last_char) begin
                        state_next = S_IDLE;
                    end else begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            S_WRAP: begin
                wr.data = INSTR_SET_DDRAM | {1'b0, wrap_target(cursor_reg)};
                wr_last = last_char;
                if (fire) begin
                    cursor_next = wrap_target(cursor_reg);
                    if (last_char) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_CHAR;
                        step_next  = step_reg + 4'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        // next command starts as soon as the current one hands off its last write
        if (done && pop_valid) begin
            step_next = '0;
            addr_next = pop_data.addr;
            char_next = pop_data.char_code;
            line_next = 1'b0;
            unique case (pop_data.kind)
                K_INIT:  state_next = S_INIT;
                K_GOTO:  state_next = S_GOTO;
                K_CHAR:  state_next = S_CHAR;
                K_CLEAR: state_next = S_CLEAR;
                K_LINE: begin
                    line_next  = 1'b1;
                    state_next = pop_data.goto_en ? S_GOTO : S_CHAR;
                end
                default: state_next = S_IDLE;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            cursor_reg  <= '0;
            line_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            cursor_reg  <= cursor_next;
            line_reg    <= line_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        char_reg <= char_next;
        if (fire) begin
            wr_out_reg <= wr;
            m_last_reg <= wr_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_reg_select = wr_out_reg.rs;
    assign m_bus_data   = wr_out_reg.data;
    assign m_poll_busy  = wr_out_reg.poll;
    assign m_settle_us  = wr_out_reg.settle;
    assign m_last       = m_last_reg;

endmodule

/* hw/rtl/char_lcd_command_sequencer.sv */
// ---------------------------------------------------------------------------
// char_lcd_command_sequencer: 16x4 character LCD command to bus-write expander
// Throughput: one write per cycle unless m_ready holds the output register; a
// command expands into 1 to 18 writes through the back sequencer's single
// write port; rejected commands produce none.
// Reset: synchronous active-low aresetn empties the queue, cursor goes to 0.
// ---------------------------------------------------------------------------
module char_lcd_command_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [7:0]  s_row,
    input  logic [7:0]  s_column,
    input  logic [7:0]  s_char_code,
    // bus-write channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_select,
    output logic [7:0]  m_bus_data,
    output logic        m_poll_busy,
    output logic [14:0] m_settle_us,
    output logic        m_last
);
    import lcdseq_pkg::*;

    // Front: decodes mode, range-checks row/column and computes the DDRAM
    // address. Invalid set-position and unknown modes are consumed here and
    // never reach the queue.
    logic push_valid;
    logic push_ready;
    cmd_t push_data;

    // Queue: lets the front keep taking commands while the back is busy
    // with a long run (init, clear line).
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    lcdseq_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_row       (s_row),
        .s_column    (s_column),
        .s_char_code (s_char_code),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    lcdseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: one write per cycle into the output register while m_ready drains it;
    // tracks the cursor and inserts the line-wrap writes after character writes.
    lcdseq_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_select (m_reg_select),
        .m_bus_data   (m_bus_data),
        .m_poll_busy  (m_poll_busy),
        .m_settle_us  (m_settle_us),
        .m_last       (m_last)
    );

`ifndef SYNTHESIS
    // data writes always poll busy
    a_data_polls: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reg_select |-> m_poll_busy)
        else $error("data write without busy poll");

    // settle delays only appear on instruction writes
    a_settle_instr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_settle_us != 15'd0) |-> !m_reg_select)
        else $error("settle delay on data write");

    // the only unpolled writes are the init function-set writes
    a_unpolled_fs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_poll_busy |-> (m_bus_data == INSTR_FUNC_SET) && !m_last)
        else $error("unexpected unpolled write");
`endif

endmodule
